/* rtl/idll_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package idll_pkg;

	localparam int OP_W  = 3;
	localparam int NUM_W = 11;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	// fixed sentinel entries of the node tables
	localparam int HEAD_ENTRY = 0;
	localparam int TAIL_ENTRY = 1;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT    = 3'd0,
		OP_PUSH_BACK     = 3'd1,
		OP_DELETE        = 3'd2,
		OP_INSERT_BEFORE = 3'd3,
		OP_INSERT_AFTER  = 3'd4,
		OP_WALK          = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_REF = 2'd2,
		ST_END     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CHECK,
		B_LINK,
		B_WALK_DATA
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic [NUM_W-1:0] num;
		logic [VAL_W-1:0] value;
		logic             needs_ref;
		logic             is_insert;
		logic             walk_head;
		logic             bad_op;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [NUM_W-1:0] number;
		logic [VAL_W-1:0] data;
	} result_t;

endpackage
`default_nettype wire

/* rtl/idll_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface idll_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [idll_pkg::OP_W-1:0]         operation;
	logic [idll_pkg::NUM_W-1:0]        insert_number;
	logic signed [idll_pkg::VAL_W-1:0] value;

	modport source (output valid, operation, insert_number, value, input ready);
	modport sink (input valid, operation, insert_number, value, output ready);
endinterface

interface idll_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [idll_pkg::ST_W-1:0]         status;
	logic [idll_pkg::NUM_W-1:0]        node_number;
	logic signed [idll_pkg::VAL_W-1:0] node_value;

	modport source (output valid, status, node_number, node_value, input ready);
	modport sink (input valid, status, node_number, node_value, output ready);
endinterface
`default_nettype wire

/* rtl/idll_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module idll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1026
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* rtl/idll_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module idll_front (
	input  logic            clk,
	input  logic            arst_n,
	idll_cmd_if.sink        cmd,
	output logic            q_valid,
	output idll_pkg::cmd_t  q_item,
	input  logic            q_pop
);
	import idll_pkg::*;

	localparam int QD     = 2;
	localparam int PTR_W  = $clog2(QD);
	localparam int FILL_W = $clog2(QD + 1);

	cmd_t              new_item;
	op_t               op;
	cmd_t              slot_q [QD];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;

	// decode the operation once into flags for the sequencer
	always_comb begin
		op = op_t'(cmd.operation);
		new_item.op        = op;
		new_item.num       = cmd.insert_number;
		new_item.value     = cmd.value;
		new_item.needs_ref = 1'b0;
		new_item.is_insert = 1'b0;
		new_item.walk_head = 1'b0;
		new_item.bad_op    = 1'b0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				new_item.is_insert = 1'b1;
			end
			OP_DELETE: begin
				new_item.needs_ref = 1'b1;
			end
			OP_INSERT_BEFORE, OP_INSERT_AFTER: begin
				new_item.needs_ref = 1'b1;
				new_item.is_insert = 1'b1;
			end
			OP_WALK: begin
				new_item.walk_head = (cmd.insert_number == '0);
				new_item.needs_ref = (cmd.insert_number != '0);
			end
			default: begin
				new_item.bad_op = 1'b1;
			end
		endcase
	end

	assign cmd.ready = (fill_q != FILL_W'(QD));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (fill_q != '0);
	assign q_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (!push && q_pop) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end
endmodule
`default_nettype wire

/* rtl/idll_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module idll_back #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  idll_pkg::cmd_t    q_item,
	output logic              q_pop,
	input  logic              res_room,
	output logic              res_valid,
	output idll_pkg::result_t res
);
	import idll_pkg::*;

	localparam int ENTRIES = CAPACITY + 2;
	localparam int EW      = $clog2(ENTRIES);
	localparam int CW      = $clog2(CAPACITY + 1);
	localparam int CMPW    = (CW > NUM_W) ? CW : NUM_W;
	localparam int SW      = CMPW + 1;
	localparam logic [EW-1:0] HEAD_E     = EW'(HEAD_ENTRY);
	localparam logic [EW-1:0] TAIL_E     = EW'(TAIL_ENTRY);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	back_state_t st_q, st_d;
	cmd_t        cur_q;
	logic        rng_bad_q;
	logic [EW-1:0] ent_q, at_q, nxt_q;
	logic [EW-1:0] head_right_q, head_right_d;
	logic [EW-1:0] tail_left_q, tail_left_d;
	logic [CW-1:0] count_q, count_d, count_inc;

	logic [EW-1:0] q_ent;
	logic          q_rng_bad;
	logic [EW-1:0] fresh;
	logic [EW-1:0] ins_at, ins_nxt, walk_nxt;
	logic          ref_bad;

	logic          l_we, r_we, v_we, d_we;
	logic [EW-1:0] l_waddr, r_waddr, v_waddr;
	logic [EW-1:0] l_wdata, r_wdata, l_rdata, r_rdata;
	logic          v_wdata, v_rdata;
	logic [VAL_W-1:0] d_rdata;

	// sentinel links live in flops, so the tables need no clearing pass
	idll_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_left (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(q_ent), .rdata(l_rdata)
	);
	idll_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_right (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(q_ent), .rdata(r_rdata)
	);
	// only entries of numbers up to the insert count are ever consulted
	idll_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_live (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(q_ent), .rdata(v_rdata)
	);
	idll_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_data (
		.clk(clk), .we(d_we), .waddr(fresh), .wdata(cur_q.value),
		.raddr(walk_nxt), .rdata(d_rdata)
	);

	assign q_ent     = EW'(SW'(q_item.num) + SW'(1));
	assign q_rng_bad = (q_item.num == '0) || (CMPW'(q_item.num) > CMPW'(count_q));
	assign fresh     = EW'(SW'(count_q) + SW'(2));
	assign count_inc = count_q + CW'(1);
	assign walk_nxt  = cur_q.walk_head ? head_right_q : r_rdata;
	assign ref_bad   = cur_q.needs_ref && (rng_bad_q || !v_rdata);

	always_comb begin
		case (cur_q.op)
			OP_PUSH_FRONT: begin
				ins_at  = HEAD_E;
				ins_nxt = head_right_q;
			end
			OP_PUSH_BACK: begin
				ins_at  = tail_left_q;
				ins_nxt = TAIL_E;
			end
			OP_INSERT_BEFORE: begin
				ins_at  = l_rdata;
				ins_nxt = ent_q;
			end
			default: begin
				ins_at  = ent_q;
				ins_nxt = r_rdata;
			end
		endcase
	end

	always_comb begin
		st_d         = st_q;
		q_pop        = 1'b0;
		res_valid    = 1'b0;
		res          = '{status: ST_OK, number: '0, data: '0};
		head_right_d = head_right_q;
		tail_left_d  = tail_left_q;
		count_d      = count_q;
		l_we = 1'b0; l_waddr = fresh; l_wdata = ins_at;
		r_we = 1'b0; r_waddr = fresh; r_wdata = ins_nxt;
		v_we = 1'b0; v_waddr = fresh; v_wdata = 1'b1;
		d_we = 1'b0;
		case (st_q)
			B_IDLE: begin
				// the result register stays free until this item reports
				if (q_valid && res_room) begin
					q_pop = 1'b1;
					st_d  = B_CHECK;
				end
			end
			B_CHECK: begin
				st_d = B_IDLE;
				if (cur_q.bad_op || ref_bad) begin
					res_valid  = 1'b1;
					res.status = ST_BAD_REF;
				end else if (cur_q.is_insert) begin
					if (count_q == FULL_COUNT) begin
						res_valid  = 1'b1;
						res.status = ST_FULL;
					end else begin
						l_we = 1'b1;
						r_we = 1'b1;
						v_we = 1'b1;
						d_we = 1'b1;
						st_d = B_LINK;
					end
				end else if (cur_q.op == OP_DELETE) begin
					v_we      = 1'b1;
					v_waddr   = ent_q;
					v_wdata   = 1'b0;
					res_valid = 1'b1;
					if (l_rdata == HEAD_E) begin
						head_right_d = r_rdata;
					end else begin
						r_we    = 1'b1;
						r_waddr = l_rdata;
						r_wdata = r_rdata;
					end
					if (r_rdata == TAIL_E) begin
						tail_left_d = l_rdata;
					end else begin
						l_we    = 1'b1;
						l_waddr = r_rdata;
						l_wdata = l_rdata;
					end
				end else if (walk_nxt == TAIL_E) begin
					res_valid  = 1'b1;
					res.status = ST_END;
				end else begin
					st_d = B_WALK_DATA;
				end
			end
			B_LINK: begin
				// second half of the splice: neighbors point at the new node
				if (at_q == HEAD_E) begin
					head_right_d = fresh;
				end else begin
					r_we    = 1'b1;
					r_waddr = at_q;
					r_wdata = fresh;
				end
				if (nxt_q == TAIL_E) begin
					tail_left_d = fresh;
				end else begin
					l_we    = 1'b1;
					l_waddr = nxt_q;
					l_wdata = fresh;
				end
				count_d    = count_inc;
				res_valid  = 1'b1;
				res.number = NUM_W'(count_inc);
				st_d       = B_IDLE;
			end
			B_WALK_DATA: begin
				res_valid  = 1'b1;
				res.number = NUM_W'(SW'(nxt_q) - SW'(1));
				res.data   = d_rdata;
				st_d       = B_IDLE;
			end
			default: begin
				st_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= B_IDLE;
			count_q      <= '0;
			head_right_q <= TAIL_E;
			tail_left_q  <= HEAD_E;
		end else begin
			st_q         <= st_d;
			count_q      <= count_d;
			head_right_q <= head_right_d;
			tail_left_q  <= tail_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_item;
			rng_bad_q <= q_rng_bad;
			ent_q     <= q_ent;
		end
		if (st_q == B_CHECK) begin
			at_q  <= ins_at;
			nxt_q <= cur_q.is_insert ? ins_nxt : walk_nxt;
		end
	end

`ifndef SYNTHESIS
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_room)
		else $error("result issued while output register busy");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("insert count beyond capacity");
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_LINK |-> $past(st_q) == B_CHECK)
		else $error("link step not preceded by check");
	a_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		head_right_q != HEAD_E && tail_left_q != TAIL_E)
		else $error("sentinel points at itself");
`endif
endmodule
`default_nettype wire

/* rtl/indexed_doubly_linked_list.sv */
// from accepted cmd beat to rsp beat: front queue, the idle and check states of idll_back and
// the output register; inserts and walks that return a node also pass link or walk data state
// the sequencer takes a new item only once the last has reported and the output has room; it
// reads the link memories and then writes neighbor links back through their single write port
// reset: asynchronous, empty list and zero insert count at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module indexed_doubly_linked_list #(
	parameter int CAPACITY = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	idll_cmd_if.sink   cmd,
	idll_rsp_if.source rsp
);
	import idll_pkg::*;

	logic    q_valid, q_pop;
	cmd_t    q_item;
	logic    res_room, res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	idll_front u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	idll_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.res_room(res_room), .res_valid(res_valid), .res(res)
	);

	assign res_room = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.node_number = out_q.number;
	assign rsp.node_value  = out_q.data;
endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import idll_pkg::*;

	localparam int CAPACITY = 1024;
	localparam int RANDOM_ITEMS = 1830;
	localparam int CALM_TAIL = 250;
	localparam int CYCLE_LIMIT = 400000;
	// codes with no operation behind them
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	class list_scoreboard;
		localparam int ENTRIES = CAPACITY + 2;

		logic [NUM_W-1:0] prev_of [ENTRIES];
		logic [NUM_W-1:0] next_of [ENTRIES];
		logic [VAL_W-1:0] stored [ENTRIES];
		bit               alive [ENTRIES];
		int unsigned      issued;
		int unsigned      live_nums [$];
		result_t          awaited [$];
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      seen [4];

		function new();
			foreach (prev_of[i]) begin
				prev_of[i] = '0;
				next_of[i] = '0;
				stored[i] = '0;
				alive[i] = 1'b0;
			end
			next_of[HEAD_ENTRY] = NUM_W'(TAIL_ENTRY);
			prev_of[TAIL_ENTRY] = NUM_W'(HEAD_ENTRY);
			issued = 0;
			errors = 0;
			checked = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		// entry of a live node, zero when the number does not name one
		function int entry_of(logic [NUM_W-1:0] num);
			int n;
			n = int'(num);
			if (n == 0 || n > int'(issued)) return 0;
			if (!alive[n + 1]) return 0;
			return n + 1;
		endfunction

		function result_t note_cmd(logic [OP_W-1:0] op, logic [NUM_W-1:0] num,
				logic [VAL_W-1:0] val);
			result_t r;
			int at;
			int ent;
			int nxt;
			int lft;
			int rgt;
			int fresh;
			bit ins;
			r.status = ST_OK;
			r.number = '0;
			r.data = '0;
			at = HEAD_ENTRY;
			ins = 1'b0;
			case (op)
			OP_PUSH_FRONT: ins = 1'b1;
			OP_PUSH_BACK: begin
				at = prev_of[TAIL_ENTRY];
				ins = 1'b1;
			end
			OP_DELETE, OP_INSERT_BEFORE, OP_INSERT_AFTER: begin
				ent = entry_of(num);
				if (ent == 0) begin
					r.status = ST_BAD_REF;
				end else if (op == OP_DELETE) begin
					lft = prev_of[ent];
					rgt = next_of[ent];
					next_of[lft] = NUM_W'(rgt);
					prev_of[rgt] = NUM_W'(lft);
					alive[ent] = 1'b0;
					for (int i = 0; i < live_nums.size(); i++)
						if (live_nums[i] == ent - 1) begin
							live_nums.delete(i);
							break;
						end
				end else begin
					at = (op == OP_INSERT_BEFORE) ? prev_of[ent] : ent;
					ins = 1'b1;
				end
			end
			OP_WALK: begin
				ent = (num == 0) ? HEAD_ENTRY : entry_of(num);
				if (num != 0 && ent == 0) begin
					r.status = ST_BAD_REF;
				end else begin
					nxt = next_of[ent];
					if (nxt == TAIL_ENTRY) begin
						r.status = ST_END;
					end else begin
						r.number = NUM_W'(nxt - 1);
						r.data = stored[nxt];
					end
				end
			end
			default: r.status = ST_BAD_REF;
			endcase
			// reference is already settled, room is tested last
			if (ins) begin
				if (issued >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					fresh = issued + 2;
					nxt = next_of[at];
					stored[fresh] = val;
					alive[fresh] = 1'b1;
					prev_of[fresh] = NUM_W'(at);
					next_of[fresh] = NUM_W'(nxt);
					prev_of[nxt] = NUM_W'(fresh);
					next_of[at] = NUM_W'(fresh);
					issued++;
					live_nums.push_back(issued);
					r.number = NUM_W'(issued);
				end
			end
			awaited.push_back(r);
			return r;
		endfunction

		function void check_rsp(logic [ST_W-1:0] st, logic [NUM_W-1:0] nbr,
				logic [VAL_W-1:0] dat);
			result_t e;
			checked++;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected rsp beat: status %0d number %0d value %0d",
					$time, st, nbr, $signed(dat));
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, e.status, st);
				errors++;
			end
			if (nbr !== e.number) begin
				$display("%0t: node_number mismatch: expected %0d, actual %0d",
					$time, e.number, nbr);
				errors++;
			end
			if (dat !== e.data) begin
				$display("%0t: node_value mismatch: expected %0d, actual %0d",
					$time, $signed(e.data), $signed(dat));
				errors++;
			end
			seen[e.status]++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	idll_cmd_if cmd();
	idll_rsp_if rsp();

	indexed_doubly_linked_list #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp)
	);

	list_scoreboard sb = new();

	bit          calm = 1'b0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned stall_left = 0;
	int unsigned cycles = 0;
	int unsigned sent = 0;
	int          walk_at = 0;

	// rsp beat as seen just before the coming rising edge
	logic              rsp_beat = 1'b0;
	logic [ST_W-1:0]   rsp_st = '0;
	logic [NUM_W-1:0]  rsp_nbr = '0;
	logic [VAL_W-1:0]  rsp_dat = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still awaited",
				CYCLE_LIMIT, sb.awaited.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_beat = rsp.valid && rsp.ready;
		rsp_st = rsp.status;
		rsp_nbr = rsp.node_number;
		rsp_dat = rsp.node_value;
	end

	// response side: check each beat, then decide on a stall for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_beat === 1'b1)
				sb.check_rsp(rsp_st, rsp_nbr, rsp_dat);
			if (stall_left != 0)
				stall_left--;
			else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 17);
			rsp.ready <= (stall_left == 0);
		end
	end

	task automatic send(logic [OP_W-1:0] op, logic [NUM_W-1:0] num, logic [VAL_W-1:0] val);
		result_t r;
		bit      took;
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.insert_number <= num;
		cmd.value <= val;
		// ready only moves at rising edges, so the falling edge shows the accepting value
		do begin
			@(negedge clk);
			took = cmd.ready;
			@(posedge clk);
		end while (!took);
		r = sb.note_cmd(op, num, val);
		sent++;
		if (op == OP_WALK)
			walk_at = (r.status == ST_OK) ? r.number : 0;
	endtask

	function automatic logic [NUM_W-1:0] pick_live();
		if (sb.live_nums.size() == 0) return '0;
		return NUM_W'(sb.live_nums[$urandom_range(0, sb.live_nums.size() - 1)]);
	endfunction

	initial begin
		logic [OP_W-1:0]  op;
		logic [NUM_W-1:0] num;
		logic [VAL_W-1:0] val;
		int               pct;
		int               ins_share;
		int               del_share;
		int               last_entry;

		cmd.valid = 1'b0;
		cmd.operation = OP_PUSH_FRONT;
		cmd.insert_number = '0;
		cmd.value = '0;
		rsp.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list and references to nodes never handed out
		send(OP_WALK, 0, 0);
		send(OP_DELETE, 0, 0);
		send(OP_WALK, 1, 0);
		send(OP_INSERT_AFTER, 1, 32'd5);
		// build 6 3 1 5 2 4 with extreme values
		send(OP_PUSH_FRONT, 0, 32'h7fff_ffff);
		send(OP_PUSH_BACK, 0, 32'h8000_0000);
		send(OP_INSERT_BEFORE, 1, 32'hffff_ffff);
		send(OP_INSERT_AFTER, 2, 32'h0000_0000);
		send(OP_INSERT_AFTER, 1, 32'h0000_0001);
		send(OP_PUSH_FRONT, 11'h7ff, 32'h5555_aaaa);
		send(OP_WALK, 0, 0);
		send(OP_WALK, 6, 0);
		send(OP_WALK, 3, 0);
		send(OP_WALK, 1, 0);
		send(OP_WALK, 4, 0);
		// deletes, dead node references, spare codes and a number never handed out
		send(OP_DELETE, 1, 0);
		send(OP_DELETE, 1, 0);
		send(OP_WALK, 1, 0);
		send(OP_INSERT_BEFORE, 1, 32'd9);
		send(OP_DELETE, 6, 0);
		send(OP_DELETE, 4, 0);
		send(OP_WALK, 2, 0);
		send(OP_SPARE_A, 1, 32'd1);
		send(OP_SPARE_B, 11'h7ff, 32'hffff_ffff);
		send(OP_WALK, 11'd1024, 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 10;
				default: stall_pct = 40;
				endcase
			end
			calm = (i >= RANDOM_ITEMS - CALM_TAIL);
			if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
				cmd.valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end

			pct = $urandom_range(0, 99);
			val = $urandom;
			num = '0;
			ins_share = (sb.issued >= CAPACITY) ? 20 : 62;
			del_share = (sb.issued >= CAPACITY) ? 25 : 8;
			if (pct < ins_share) begin
				case ($urandom_range(0, 3))
				0: op = OP_PUSH_FRONT;
				1: op = OP_PUSH_BACK;
				2: op = OP_INSERT_BEFORE;
				default: op = OP_INSERT_AFTER;
				endcase
				if (op == OP_INSERT_BEFORE || op == OP_INSERT_AFTER)
					num = pick_live();
			end else if (pct < ins_share + del_share) begin
				op = OP_DELETE;
				num = pick_live();
			end else if (pct < 90) begin
				// mostly chains of walks, sometimes from the head, the last node or a random live node
				op = OP_WALK;
				case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5:
					num = (sb.entry_of(NUM_W'(walk_at)) != 0) ? NUM_W'(walk_at) : '0;
				6: num = '0;
				7: begin
					last_entry = sb.prev_of[TAIL_ENTRY];
					num = (last_entry == HEAD_ENTRY) ? '0 : NUM_W'(last_entry - 1);
				end
				default: num = pick_live();
				endcase
			end else begin
				op = OP_W'($urandom_range(OP_PUSH_FRONT, OP_SPARE_B));
				case ($urandom_range(0, 2))
				0: num = NUM_W'($urandom_range(0, 2047));
				1: num = NUM_W'($urandom_range(0, sb.issued + 2));
				default: num = pick_live();
				endcase
			end
			send(op, num, val);
		end
		cmd.valid <= 1'b0;

		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("%0d operations, %0d rsp beats checked: ok %0d, full %0d, bad ref %0d, end %0d",
			sent, sb.checked, sb.seen[ST_OK], sb.seen[ST_FULL], sb.seen[ST_BAD_REF],
			sb.seen[ST_END]);
		$display("insert numbers issued %0d of %0d, live nodes at the end %0d",
			sb.issued, CAPACITY, sb.live_nums.size());
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
rtl/idll_pkg.sv
rtl/idll_if.sv
rtl/idll_ram.sv
rtl/idll_front.sv
rtl/idll_back.sv
rtl/indexed_doubly_linked_list.sv
bench/tb_top.sv
